### design/tlik_pkg.sv
package tlik_pkg;

  localparam int CORDIC_STAGES = 16;
  localparam int CW = 44;
  localparam int ZW = 26;
  localparam int SQ_STEPS = 32;
  localparam int NORM_STEPS = 6;

  localparam logic signed [ZW-1:0] DEG90_FINE = 26'sd5898240;
  localparam logic signed [16:0] DEG180_64 = 17'sd11520;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_REACH = 2'd1;
  localparam logic [1:0] ST_ZERO = 2'd2;

  localparam logic [1:0] REG_BASE = 2'd0;
  localparam logic [1:0] REG_LOWER = 2'd1;
  localparam logic [1:0] REG_UPPER = 2'd2;

  typedef struct packed {
    logic [1:0] status;
    logic xneg;
    logic yneg;
  } flags_t;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
  } cvec_t;

  function automatic logic signed [ZW-1:0] atan_fine(input int i);
    case (i)
      0: atan_fine = 26'sd2949120;
      1: atan_fine = 26'sd1740967;
      2: atan_fine = 26'sd919879;
      3: atan_fine = 26'sd466945;
      4: atan_fine = 26'sd234379;
      5: atan_fine = 26'sd117304;
      6: atan_fine = 26'sd58666;
      7: atan_fine = 26'sd29335;
      8: atan_fine = 26'sd14668;
      9: atan_fine = 26'sd7334;
      10: atan_fine = 26'sd3667;
      11: atan_fine = 26'sd1833;
      12: atan_fine = 26'sd917;
      13: atan_fine = 26'sd458;
      14: atan_fine = 26'sd229;
      15: atan_fine = 26'sd115;
      16: atan_fine = 26'sd57;
      17: atan_fine = 26'sd29;
      18: atan_fine = 26'sd14;
      19: atan_fine = 26'sd7;
      20: atan_fine = 26'sd4;
      21: atan_fine = 26'sd2;
      22: atan_fine = 26'sd1;
      default: atan_fine = '0;
    endcase
  endfunction

  function automatic logic signed [16:0] to_64ths(input logic signed [ZW-1:0] f);
    logic signed [ZW:0] t;
    t = {f[ZW-1], f} + (ZW+1)'(512);
    to_64ths = 17'(t >>> 10);
  endfunction

endpackage

### design/two_link_arm_inverse_kinematics.sv
// Two-link arm inverse kinematics.
// Requests enter on s_axis (tdata = pos_x, pos_y, pos_z, 48 bits) and results
// leave on m_axis (tdata = base_angle, lower_angle, upper_angle, status, 47 bits
// with zero fill to 48). The user sets link geometry through the write port
// (cfg_we, cfg_addr, cfg_data) only while no request is in flight; not enforced.
// Every stage is a fixed cell in a row: four setup stages, a 32-cell square
// root, six normalize cells and CORDIC_STAGES (16) rotation cells, 58
// registers in all.
// One request is taken per cycle while s_axis_tready is high. Results from the last
// rotation cells of the atan pipes collect in a 64-entry queue whose head
// is a register. s_axis_tready drops once queued plus in-flight results reach
// 64, so a stalled receiver pauses intake and no result is lost.
// Reset empties the pipe and queue and restores the default geometry.
module two_link_arm_inverse_kinematics (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // pos_x, pos_y, pos_z
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // base_angle, lower_angle, upper_angle, status
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [14:0] cfg_data
);
  import tlik_pkg::*;
  localparam int LAT = 4 + SQ_STEPS + NORM_STEPS + CORDIC_STAGES;
  localparam int QD = 64;

  logic [14:0] shoulder_height, lower_length, upper_reach;
  always_ff @(posedge clk) begin
    if (rst) begin
      shoulder_height <= 15'd512;
      lower_length <= 15'd1280;
      upper_reach <= 15'd1344;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_BASE: shoulder_height <= cfg_data;
        REG_LOWER: lower_length <= cfg_data;
        REG_UPPER: upper_reach <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: squares
  logic signed [16:0] x1, yb1, z1, yb_c;
  logic [31:0] r2a, r2b, ll, uu, lu;
  logic [15:0] lmu1, lpu1;
  logic fire;
  assign fire = s_axis_tvalid && s_axis_tready;
  assign yb_c = 17'(signed'(s_axis_tdata[31:16])) - signed'({2'b00, shoulder_height});
  always_ff @(posedge clk) begin
    x1 <= 17'(signed'(s_axis_tdata[15:0]));
    yb1 <= yb_c;
    z1 <= 17'(signed'(s_axis_tdata[47:32]));
    r2a <= 32'(signed'(s_axis_tdata[15:0]) * signed'(s_axis_tdata[15:0]));
    r2b <= 32'(yb_c * yb_c);
    ll <= 32'(lower_length) * 32'(lower_length);
    uu <= 32'(upper_reach) * 32'(upper_reach);
    lu <= 32'(lower_length) * 32'(upper_reach);
    lmu1 <= (lower_length > upper_reach) ? 16'(lower_length - upper_reach)
                                         : 16'(upper_reach - lower_length);
    lpu1 <= 16'(lower_length) + 16'(upper_reach);
  end

  // stage 2: reach, numerators, bound squares
  logic [32:0] r2q;
  logic signed [34:0] ne2, ns2;
  logic [31:0] lmq2, lpq2;
  logic [63:0] de2;
  logic [29:0] ll2;
  logic signed [16:0] x2, yb2, z2;
  always_ff @(posedge clk) begin
    r2q <= 33'(r2a) + 33'(r2b);
    ne2 <= 35'(ll) + 35'(uu) - 35'(r2a) - 35'(r2b);
    ns2 <= 35'(ll) - 35'(uu) + 35'(r2a) + 35'(r2b);
    lmq2 <= 32'(lmu1) * 32'(lmu1);
    lpq2 <= 32'(lpu1) * 32'(lpu1);
    de2 <= {2'b00, 60'(lu[29:0] * lu[29:0]), 2'b00};
    ll2 <= ll[29:0];
    x2 <= x1; yb2 <= yb1; z2 <= z1;
  end

  // stage 3: squared numerators, shoulder denominator, flags
  logic [32:0] ane, ans;
  logic [63:0] de3, ds3, nne3, nns3;
  logic signed [34:0] ne3, ns3;
  logic signed [16:0] x3, yb3, z3;
  flags_t f3;
  always_comb begin
    ane = 33'(ne2[34] ? -ne2 : ne2);
    ans = 33'(ns2[34] ? -ns2 : ns2);
  end
  always_ff @(posedge clk) begin
    de3 <= de2;
    ds3 <= {62'(ll2 * r2q), 2'b00};
    nne3 <= 64'(ane * ane);
    nns3 <= 64'(ans * ans);
    ne3 <= ne2; ns3 <= ns2;
    x3 <= x2; yb3 <= yb2; z3 <= z2;
    f3.xneg <= x2[16];
    f3.yneg <= yb2[16];
    if (lower_length == '0 || upper_reach == '0 || r2q == '0
        || r2q < 33'(lmq2) || r2q > 33'(lpq2))
      f3.status <= ST_REACH;
    else if (x2 == '0 || yb2 == '0)
      f3.status <= ST_ZERO;
    else
      f3.status <= ST_OK;
  end

  // stage 4: radicands
  logic [63:0] rad_e, rad_s;
  always_ff @(posedge clk) begin
    rad_e <= (de3 >= nne3) ? de3 - nne3 : '0;
    rad_s <= (ds3 >= nns3) ? ds3 - nns3 : '0;
  end

  // square root rows, with side data delayed alongside
  logic [63:0] er [0:SQ_STEPS], sr [0:SQ_STEPS], ep [0:SQ_STEPS], sp [0:SQ_STEPS];
  logic [31:0] eq [0:SQ_STEPS], sq [0:SQ_STEPS];
  assign er[0] = '0; assign sr[0] = '0; assign eq[0] = '0; assign sq[0] = '0;
  assign ep[0] = rad_e; assign sp[0] = rad_s;
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    tlik_sqrt_cell u_e (.clk(clk), .rem_in(er[k]), .root_in(eq[k]), .rem_pass_in(ep[k]),
      .rem_out(er[k+1]), .root_out(eq[k+1]), .rem_pass_out(ep[k+1]));
    tlik_sqrt_cell u_s (.clk(clk), .rem_in(sr[k]), .root_in(sq[k]), .rem_pass_in(sp[k]),
      .rem_out(sr[k+1]), .root_out(sq[k+1]), .rem_pass_out(sp[k+1]));
  end
  localparam int SW = 35 + 35 + 17 + 17 + 17 + 4;
  logic [SW-1:0] sd [1:SQ_STEPS+1];
  always_ff @(posedge clk) begin
    sd[1] <= {ne3, ns3, x3, yb3, z3, f3};
    for (int k = 1; k <= SQ_STEPS; k++) sd[k+1] <= sd[k];
  end
  logic signed [34:0] ne_d, ns_d;
  logic signed [16:0] x_d, yb_d, z_d;
  flags_t f_d;
  assign {ne_d, ns_d, x_d, yb_d, z_d, f_d} = sd[SQ_STEPS+1];

  // four atan pipes
  logic signed [42:0] ax_e, ay_e, ax_s, ay_s, ax_t, ay_t, ax_b, ay_b;
  always_comb begin
    if (ne_d[34]) begin ax_e = 43'(eq[SQ_STEPS]); ay_e = 43'(-ne_d); end
    else begin ax_e = 43'(ne_d); ay_e = 43'(eq[SQ_STEPS]); end
    if (ns_d[34]) begin ax_s = 43'(sq[SQ_STEPS]); ay_s = 43'(-ns_d); end
    else begin ax_s = 43'(ns_d); ay_s = 43'(sq[SQ_STEPS]); end
    if (!yb_d[16]) begin ax_t = 43'(yb_d); ay_t = 43'(x_d); end
    else begin ax_t = 43'(-yb_d); ay_t = 43'(-x_d); end
    if (x_d > 0) begin ax_b = 43'(x_d); ay_b = 43'(z_d); end
    else begin ax_b = 43'(-x_d); ay_b = 43'(-z_d); end
  end
  logic signed [ZW-1:0] ang_e, ang_s, ang_t, ang_b;
  tlik_atan_pipe u_ae (.clk(clk), .cx(ax_e), .cy(ay_e), .ang(ang_e));
  tlik_atan_pipe u_as (.clk(clk), .cx(ax_s), .cy(ay_s), .ang(ang_s));
  tlik_atan_pipe u_at (.clk(clk), .cx(ax_t), .cy(ay_t), .ang(ang_t));
  tlik_atan_pipe u_ab (.clk(clk), .cx(ax_b), .cy(ay_b), .ang(ang_b));

  localparam int AD = NORM_STEPS + CORDIC_STAGES;
  logic [5:0] ad [1:AD];
  always_ff @(posedge clk) begin
    ad[1] <= {ne_d[34], ns_d[34], f_d};
    for (int k = 1; k < AD; k++) ad[k+1] <= ad[k];
  end
  logic eneg, sneg;
  flags_t f_a;
  assign {eneg, sneg, f_a} = ad[AD];

  logic signed [16:0] e64, s64, t64, b64, lo, up;
  always_comb begin
    e64 = to_64ths(eneg ? ang_e + DEG90_FINE : ang_e);
    s64 = to_64ths(sneg ? ang_s + DEG90_FINE : ang_s);
    t64 = to_64ths(ang_t);
    b64 = to_64ths(ang_b);
    if (f_a.xneg) begin lo = t64 - s64; up = DEG180_64 - e64; end
    else begin lo = s64 - t64; up = e64 - DEG180_64; end
  end

  // valid tracking and output queue
  logic [LAT-1:0] vpipe;
  logic [47:0] res;
  assign res = (f_a.status != ST_OK) ? {1'b0, f_a.status, 45'd0}
               : {1'b0, f_a.status, up[14:0], lo[15:0], b64[13:0]};
  logic [47:0] q [0:QD-1];
  logic [47:0] head;
  logic [5:0] wp, rp, rp_next;
  logic [6:0] cnt, inflight;
  logic push, pop;
  assign push = vpipe[LAT-1];
  assign pop = m_axis_tvalid && m_axis_tready;
  assign rp_next = pop ? rp + 6'd1 : rp;
  always_ff @(posedge clk) begin
    if (rst) begin
      vpipe <= '0; wp <= '0; rp <= '0; cnt <= '0; inflight <= '0;
    end else begin
      vpipe <= {vpipe[LAT-2:0], fire};
      inflight <= inflight + 7'(fire) - 7'(push);
      cnt <= cnt + 7'(push) - 7'(pop);
      if (push) wp <= wp + 6'd1;
      rp <= rp_next;
    end
  end
  always_ff @(posedge clk) begin
    if (push) q[wp] <= res;
    head <= (push && wp == rp_next) ? res : q[rp_next];
  end
  assign s_axis_tready = (cnt + inflight) < 7'(QD);
  assign m_axis_tvalid = cnt != '0;
  assign m_axis_tdata = head;
endmodule

### design/tlik_sqrt_cell.sv
module tlik_sqrt_cell (
  input  logic        clk,
  input  logic [63:0] rem_in,
  input  logic [31:0] root_in,
  input  logic [63:0] rem_pass_in,
  output logic [63:0] rem_out,
  output logic [31:0] root_out,
  output logic [63:0] rem_pass_out
);
  // one restoring root digit per cell; rem_pass_in holds remaining radicand bits
  logic [65:0] trial;
  logic [65:0] cur;
  always_comb begin
    cur = {rem_in[63:0], rem_pass_in[63:62]};
    trial = cur - {32'd0, root_in, 2'b01};
  end
  always_ff @(posedge clk) begin
    if (!trial[65]) begin
      rem_out <= trial[63:0];
      root_out <= {root_in[30:0], 1'b1};
    end else begin
      rem_out <= cur[63:0];
      root_out <= {root_in[30:0], 1'b0};
    end
    rem_pass_out <= {rem_pass_in[61:0], 2'b00};
  end
endmodule

### design/tlik_cordic_cell.sv
module tlik_cordic_cell (
  input  logic clk,
  input  logic [4:0] idx,
  input  tlik_pkg::cvec_t v_in,
  output tlik_pkg::cvec_t v_out
);
  import tlik_pkg::*;
  logic signed [CW-1:0] dx, dy;
  always_comb begin
    dx = v_in.y >>> idx;
    dy = v_in.x >>> idx;
  end
  always_ff @(posedge clk) begin
    if (v_in.y > 0) begin
      v_out.x <= v_in.x + dx;
      v_out.y <= v_in.y - dy;
      v_out.z <= v_in.z + atan_fine(int'(idx));
    end else begin
      v_out.x <= v_in.x - dx;
      v_out.y <= v_in.y + dy;
      v_out.z <= v_in.z - atan_fine(int'(idx));
    end
  end
endmodule

### design/tlik_norm_cell.sv
module tlik_norm_cell (
  input  logic clk,
  input  logic [2:0] step,
  input  tlik_pkg::cvec_t v_in,
  output tlik_pkg::cvec_t v_out
);
  import tlik_pkg::*;
  // shift left by 32 >> step bits while the larger magnitude stays below 2^40
  logic [5:0] sh;
  logic [CW-1:0] ax, ay, m;
  always_comb begin
    sh = 6'(6'd32 >> step);
    ax = v_in.x[CW-1] ? CW'(-v_in.x) : CW'(v_in.x);
    ay = v_in.y[CW-1] ? CW'(-v_in.y) : CW'(v_in.y);
    m = (ax > ay) ? ax : ay;
  end
  always_ff @(posedge clk) begin
    v_out.z <= v_in.z;
    if (m != '0 && (m << sh) < (CW'(1) << 40) + CW'(0) && (m >> (CW - int'(sh) - 1)) == '0) begin
      v_out.x <= v_in.x <<< sh;
      v_out.y <= v_in.y <<< sh;
    end else begin
      v_out.x <= v_in.x;
      v_out.y <= v_in.y;
    end
  end
endmodule

### design/tlik_atan_pipe.sv
module tlik_atan_pipe (
  input  logic clk,
  input  logic signed [42:0] cx,
  input  logic signed [42:0] cy,
  output logic signed [tlik_pkg::ZW-1:0] ang
);
  import tlik_pkg::*;
  cvec_t nv [0:NORM_STEPS];
  cvec_t cv [0:CORDIC_STAGES];
  logic signed [CW-1:0] ax, ay;
  always_comb begin
    nv[0].x = CW'(cx);
    nv[0].y = CW'(cy);
    nv[0].z = '0;
  end
  // final pass: one more doubling when still below the limit
  always_comb begin
    ax = nv[NORM_STEPS].x;
    ay = nv[NORM_STEPS].y[CW-1] ? -nv[NORM_STEPS].y : nv[NORM_STEPS].y;
    cv[0] = nv[NORM_STEPS];
    if (((ax > ay) ? ax : ay) != '0 && ((ax > ay) ? ax : ay) < (CW'(1) << 40)) begin
      cv[0].x = nv[NORM_STEPS].x <<< 1;
      cv[0].y = nv[NORM_STEPS].y <<< 1;
    end
  end
  for (genvar k = 0; k < NORM_STEPS; k++) begin : g_norm
    tlik_norm_cell u_n (.clk(clk), .step(3'(k)), .v_in(nv[k]), .v_out(nv[k+1]));
  end
  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    tlik_cordic_cell u_c (.clk(clk), .idx(5'(i)), .v_in(cv[i]), .v_out(cv[i+1]));
  end
  assign ang = cv[CORDIC_STAGES].z;
endmodule

### design/tlik_checker.sv
module tlik_checker (
  input logic clk,
  input logic rst,
  input logic s_axis_tready,
  input logic m_axis_tvalid,
  input logic m_axis_tready,
  input logic [47:0] m_axis_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_stat: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[46:45] != 2'd3)
    else $error("bad status");
  a_rst: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("valid after reset");
  a_rdy: assert property (@(posedge clk) rst |=> s_axis_tready)
    else $error("not ready after reset");
endmodule

bind two_link_arm_inverse_kinematics tlik_checker u_chk (.*);
